/* sv/brb_pkg.sv */
// shared constants, types and helpers for the byte ring buffer
package brb_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FILL_W  = 11;
  localparam int unsigned TDATA_W = 16;
  localparam int unsigned TUSER_W = 2;
  localparam int unsigned RES_W   = 40;

  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_e;

  typedef struct packed {
    logic              is_full;
    logic              is_empty;
    logic [FILL_W-1:0] fill_count;
    logic [FILL_W-1:0] distance;
    logic              ok;
    logic [BYTE_W-1:0] data_out;
  } result_t;

  function automatic logic [ADDR_W-1:0] next_pos(input logic [ADDR_W-1:0] pos);
    logic [ADDR_W-1:0] nxt;
    nxt = (pos == ADDR_W'(DEPTH - 1)) ? '0 : pos + 1'b1;
    return nxt;
  endfunction

endpackage

/* sv/brb_ram.sv */
// simple dual-port byte ram with registered read data
module brb_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/brb_ctrl.sv */
// pointer state, sequencer and byte compare unit of the ring buffer
module brb_ctrl import brb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_kind_i,
  input  logic [BYTE_W-1:0] in_data_i,
  input  logic [BYTE_W-1:0] in_search_i,
  input  logic              out_free_i,
  output logic              res_valid_o,
  output result_t           res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GET,
    ST_SCAN
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] rd_pos_q, rd_pos_d;
  logic [ADDR_W-1:0] wr_pos_q, wr_pos_d;
  logic [FILL_W-1:0] occ_q, occ_d;
  logic [ADDR_W-1:0] scan_pos_q, scan_pos_d;
  logic [ADDR_W-1:0] checked_q, checked_d;
  logic [BYTE_W-1:0] target_q, target_d;

  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [BYTE_W-1:0] ram_rd_data;

  logic              accept;
  logic              hit;
  logic              last;
  logic [FILL_W-1:0] checked_inc;

  brb_ram #(
    .DATA_W (BYTE_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (wr_pos_q),
    .wr_data_i (in_data_i),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  assign in_ready_o  = (state_q == ST_IDLE) && out_free_i;
  assign accept      = in_valid_i && in_ready_o;
  assign checked_inc = FILL_W'(checked_q) + 1'b1;
  assign hit         = (ram_rd_data == target_q);
  assign last        = (checked_inc == occ_q);

  always_comb begin
    state_d     = state_q;
    rd_pos_d    = rd_pos_q;
    wr_pos_d    = wr_pos_q;
    occ_d       = occ_q;
    scan_pos_d  = scan_pos_q;
    checked_d   = checked_q;
    target_d    = target_q;
    ram_wr_en   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = rd_pos_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind_i)
            KIND_PUT: begin
              res_valid_o = 1'b1;
              if (occ_q != FILL_W'(DEPTH)) begin
                ram_wr_en = 1'b1;
                wr_pos_d  = next_pos(wr_pos_q);
                occ_d     = occ_q + 1'b1;
                res_o.ok  = 1'b1;
              end
            end
            KIND_GET: begin
              if (occ_q != '0) begin
                ram_rd_en = 1'b1;
                state_d   = ST_GET;
              end else begin
                res_valid_o = 1'b1;
              end
            end
            KIND_SEARCH: begin
              if (occ_q != '0) begin
                ram_rd_en  = 1'b1;
                scan_pos_d = next_pos(rd_pos_q);
                checked_d  = '0;
                target_d   = in_search_i;
                state_d    = ST_SCAN;
              end else begin
                res_valid_o = 1'b1;
              end
            end
            default: begin
              res_valid_o = 1'b1;
            end
          endcase
        end
      end
      ST_GET: begin
        res_valid_o    = 1'b1;
        res_o.ok       = 1'b1;
        res_o.data_out = ram_rd_data;
        rd_pos_d       = next_pos(rd_pos_q);
        occ_d          = occ_q - 1'b1;
        state_d        = ST_IDLE;
      end
      ST_SCAN: begin
        if (hit || last) begin
          res_valid_o    = 1'b1;
          res_o.ok       = hit;
          res_o.distance = hit ? checked_inc : '0;
          state_d        = ST_IDLE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = scan_pos_q;
          scan_pos_d  = next_pos(scan_pos_q);
          checked_d   = checked_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_o.fill_count = occ_d;
    res_o.is_empty   = (occ_d == '0);
    res_o.is_full    = (occ_d == FILL_W'(DEPTH));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_pos_q <= '0;
      wr_pos_q <= '0;
      occ_q    <= '0;
    end else begin
      state_q  <= state_d;
      rd_pos_q <= rd_pos_d;
      wr_pos_q <= wr_pos_d;
      occ_q    <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_pos_q <= scan_pos_d;
    checked_q  <= checked_d;
    target_q   <= target_d;
  end

endmodule

/* sv/byte_ring_buffer_with_delimiter_search.sv */
// top level: byte ring buffer with delimiter search and registered result port
// put, unused kind, or get/search on an empty buffer: result registered the cycle after accept
// get: result passes the registered ram read, then the output register
// search: compares k bytes (1..fill count), one per ram read, then loads the output register
// throughput: one put per cycle unless output stalls; single ram read port paces gets, searches
// reset: rst_ni clears pointers, fill count and the output valid; the byte ram is not cleared
module byte_ring_buffer_with_delimiter_search import brb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,  // data_in[7:0], search_byte[15:8]
  input  logic [TUSER_W-1:0] s_axis_tuser_i,  // kind[1:0]
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [RES_W-1:0]   m_axis_tdata_o   // data_out[7:0], ok[8], distance[19:9],
                                              // fill_count[30:20], is_empty[31],
                                              // is_full[32], zero fill[39:33]
);

  logic             m_valid_q;
  logic [RES_W-1:0] m_data_q;
  logic             out_free;
  logic             res_valid;
  result_t          res;

  // the output register is free when empty or being drained this cycle
  assign out_free = !m_valid_q || m_axis_tready_i;

  brb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_kind_i   (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i[BYTE_W-1:0]),
    .in_search_i (s_axis_tdata_i[2*BYTE_W-1:BYTE_W]),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register: loaded with each finished result, cleared when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // payload packed from the lowest bit up, zero filled to whole bytes
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_data_q <= RES_W'(res);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef SYNTHESIS
  // a finished result never overwrites one still waiting at the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free)
    else $error("result produced while output register is stalled");

  // a put always answers in the next cycle, accepted or refused
  a_put_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == KIND_PUT)) |=> m_valid_q)
    else $error("put did not produce a result");

  // reported fill level never exceeds the buffer depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_data_q[30:20] <= FILL_W'(DEPTH)))
    else $error("fill count above depth");

  // a get either answers at once (empty ring) or holds off the input while it reads
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == KIND_GET))
      |=> (m_valid_q || !s_axis_tready_o))
    else $error("item accepted during a get");
`endif

endmodule
